@@ rtl/hdr_pkg.sv @@
// shared constants, types and tables for the haversine distance pipeline
`timescale 1ns / 1ps
package hdr_pkg;

    // number of circular cordic micro-rotations, valid from 12 to 32
    localparam int CORDIC_STAGES = 24;

    // preprocess register, one register per micro-rotation, output register
    localparam int LAT_CORDIC = CORDIC_STAGES + 2;

    // digit-by-digit square root, one result bit per stage
    localparam int SQRT_STEPS = 31;
    localparam int LAT_SQRT   = SQRT_STEPS;

    // cordic datapath width and square root remainder width
    localparam int CW = 34;
    localparam int SW = 35;

    localparam logic signed [CW-1:0] CW_Q30  = 34'sd1073741824;
    localparam logic signed [CW-1:0] CW_HALF = 34'sd2147483648;
    localparam logic signed [CW-1:0] CW_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] CW_ATAN_MAX = 34'sd268435456;

    // low part of round(2^64 / 3.6e9); the 2^32 part is an add of the angle itself
    localparam logic signed [63:0] DEG_K_LO  = 64'sd829128280;
    localparam logic signed [63:0] DEG_ROUND = 64'sd2147483648;

    localparam logic [30:0] SCALE_METER = 31'd1280965555;
    localparam logic [30:0] SCALE_YARD  = 31'd1400876741;
    localparam logic [60:0] DIST_ROUND  = 61'd4294967296;

    localparam logic FUNC_METER = 1'b0;
    localparam logic FUNC_YARD  = 1'b1;

    typedef enum logic {
        CORDIC_ROTATE,
        CORDIC_VECTOR
    } cordic_mode_t;

    // arctangent of 2^-idx in binary turns
    function automatic logic [31:0] atan_turn(input int unsigned idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/hdr_cordic.sv @@
// pipelined circular cordic: cosine in rotation mode, clamped atan2 in vectoring mode
`timescale 1ns / 1ps
module hdr_cordic (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hdr_pkg::cordic_mode_t mode,
    input  logic                 in_valid,
    input  logic [31:0]          angle,
    input  logic signed [31:0]   x_in,
    input  logic signed [31:0]   y_in,
    output logic                 out_valid,
    output logic signed [31:0]   result
);
    import hdr_pkg::*;

    logic [CORDIC_STAGES:0]  valid_reg;
    logic [CORDIC_STAGES:0]  neg_reg;
    logic signed [CW-1:0]    x_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0]    y_reg [0:CORDIC_STAGES];
    logic signed [CW-1:0]    z_reg [0:CORDIC_STAGES];

    logic signed [CW-1:0]    x_pre_next;
    logic signed [CW-1:0]    y_pre_next;
    logic signed [CW-1:0]    z_pre_next;
    logic                    neg_pre_next;
    logic signed [CW-1:0]    z_ext;

    logic                    out_valid_reg;
    logic signed [31:0]      result_reg;
    logic signed [31:0]      result_next;

    // rotation folds the angle into the right half plane, negating the cosine after
    always_comb
    begin
        z_ext        = CW'($signed(angle));
        x_pre_next   = CW_GAIN;
        y_pre_next   = '0;
        z_pre_next   = z_ext;
        neg_pre_next = 1'b0;
        if (mode == CORDIC_ROTATE)
        begin
            if (z_ext > CW_Q30)
            begin
                z_pre_next   = z_ext - CW_HALF;
                neg_pre_next = 1'b1;
            end
            else if (z_ext < -CW_Q30)
            begin
                z_pre_next   = z_ext + CW_HALF;
                neg_pre_next = 1'b1;
            end
        end
        else
        begin
            x_pre_next = CW'(x_in);
            y_pre_next = CW'(y_in);
            z_pre_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]   <= x_pre_next;
        y_reg[0]   <= y_pre_next;
        z_reg[0]   <= z_pre_next;
        neg_reg[0] <= neg_pre_next;
    end

    for (genvar s = 1; s <= CORDIC_STAGES; s++)
    begin : g_stage
        logic                 dir_pos;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        logic signed [CW-1:0] at;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;

        always_comb
        begin
            dx = y_reg[s-1] >>> (s - 1);
            dy = x_reg[s-1] >>> (s - 1);
            at = $signed({{(CW-32){1'b0}}, atan_turn(s - 1)});
            if (mode == CORDIC_ROTATE)
            begin
                dir_pos = !z_reg[s-1][CW-1];
            end
            else
            begin
                // drive y toward zero
                dir_pos = !(!y_reg[s-1][CW-1] && (y_reg[s-1] != '0));
            end
            if (dir_pos)
            begin
                x_next = x_reg[s-1] - dx;
                y_next = y_reg[s-1] + dy;
                z_next = z_reg[s-1] - at;
            end
            else
            begin
                x_next = x_reg[s-1] + dx;
                y_next = y_reg[s-1] - dy;
                z_next = z_reg[s-1] + at;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[s]   <= x_next;
            y_reg[s]   <= y_next;
            z_reg[s]   <= z_next;
            neg_reg[s] <= neg_reg[s-1];
        end
    end

    always_comb
    begin
        if (mode == CORDIC_ROTATE)
        begin
            if (neg_reg[CORDIC_STAGES])
            begin
                result_next = 32'(-x_reg[CORDIC_STAGES]);
            end
            else
            begin
                result_next = 32'(x_reg[CORDIC_STAGES]);
            end
        end
        else if (z_reg[CORDIC_STAGES][CW-1])
        begin
            result_next = '0;
        end
        else if (z_reg[CORDIC_STAGES] > CW_ATAN_MAX)
        begin
            result_next = 32'(CW_ATAN_MAX);
        end
        else
        begin
            result_next = 32'(z_reg[CORDIC_STAGES]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

@@ rtl/hdr_isqrt.sv @@
// pipelined digit-by-digit square root of a q30 value, result in q30
`timescale 1ns / 1ps
module hdr_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [30:0] value,
    output logic        out_valid,
    output logic [30:0] root
);
    import hdr_pkg::*;

    logic [SQRT_STEPS-1:0] valid_reg;
    logic [61:0]           n_reg    [0:SQRT_STEPS-1];
    logic [SW-1:0]         rem_reg  [0:SQRT_STEPS-1];
    logic [30:0]           root_reg [0:SQRT_STEPS-1];

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_step
        logic          v_prev;
        logic [61:0]   n_prev;
        logic [SW-1:0] rem_prev;
        logic [30:0]   root_prev;
        logic [SW-1:0] rem_sh;
        logic [SW-1:0] trial;
        logic          take;
        logic [SW-1:0] rem_next;
        logic [30:0]   root_next;

        if (k == 0)
        begin : g_first
            assign v_prev    = in_valid;
            assign n_prev    = {1'b0, value, 30'd0};
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_rest
            assign v_prev    = valid_reg[k-1];
            assign n_prev    = n_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        always_comb
        begin
            rem_sh    = {rem_prev[SW-3:0], n_prev[61-2*k -: 2]};
            trial     = {{(SW-33){1'b0}}, root_prev, 2'b01};
            take      = rem_sh >= trial;
            rem_next  = take ? rem_sh - trial : rem_sh;
            root_next = {root_prev[29:0], take};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            n_reg[k]    <= n_prev;
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root      = root_reg[SQRT_STEPS-1];

endmodule

@@ rtl/haversine_distance_remaining.sv @@
// top level: great-circle distance by haversine, subtracted from a reference distance
`timescale 1ns / 1ps
// usage
//   request channel: drive the fields and raise start for one cycle per request.
//   busy is always low, so a request is taken at every clock edge where start
//   is high, one per cycle with no gaps needed.
//   result channel: done is high for exactly one cycle while remaining_distance
//   holds the result; results leave in request order and the receiver has
//   no way to hold them, so it must take each one as it appears.
//   depth: set by the two cordic pipelines (cosines, then arctangent) and the
//   31 stage square root between them.
//   throughput: one request per cycle, every unit is fully pipelined.
//   reset: rst_n clears all valid bits at once; requests in flight are dropped
//   and no done pulse comes for them. no warm-up is needed after reset.
module haversine_distance_remaining (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [30:0] start_latitude,
    input  logic signed [31:0] start_longitude,
    input  logic signed [30:0] end_latitude,
    input  logic signed [31:0] end_longitude,
    input  logic [19:0]        reference_distance,
    output logic               done,
    output logic signed [29:0] remaining_distance
);
    import hdr_pkg::*;

    localparam int SIDE_DEPTH = 6 + 2 * LAT_CORDIC + LAT_SQRT;

    // degrees to binary turns, second half: add the 2^32 part and round
    function automatic logic [31:0] deg_turn(input logic [31:0] v, input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p + DEG_ROUND;
        return v + s[63:32];
    endfunction

    // (1 - cos) / 2 clamped to [0, 1] in q30
    function automatic logic [30:0] hav(input logic signed [31:0] c);
        logic signed [CW-1:0] t;
        logic [30:0]          r;
        t = (CW_Q30 - CW'(c)) >>> 1;
        if (t[CW-1])
        begin
            r = '0;
        end
        else if (t > CW_Q30)
        begin
            r = 31'(CW_Q30);
        end
        else
        begin
            r = 31'(t);
        end
        return r;
    endfunction

    // stage 1: angle times the low part of the degree scale
    logic               v1_reg;
    logic [31:0]        slat_v_reg, slon_v_reg, elat_v_reg, elon_v_reg;
    logic signed [63:0] slat_p_reg, slon_p_reg, elat_p_reg, elon_p_reg;
    logic signed [63:0] slat_p_next, slon_p_next, elat_p_next, elon_p_next;

    // stage 2: turns
    logic               v2_reg;
    logic [31:0]        slat_t_reg, slon_t_reg, elat_t_reg, elon_t_reg;

    // stage 3: differences and the two latitudes
    logic               v3_reg;
    logic [31:0]        dlat_reg, dlon_reg, lat1_reg, lat2_reg;
    logic [31:0]        dlat_next, dlon_next;

    // cosine lanes
    logic               cdlat_valid, cdlon_valid, clat1_valid, clat2_valid;
    logic signed [31:0] cdlat, cdlon, clat1, clat2;

    // stages a, b, c: haversine terms
    logic               va_reg, vb_reg, vc_reg;
    logic [30:0]        hlat_a_reg, hlon_a_reg, hlat_b_reg;
    logic signed [63:0] ccp_reg, ccp_next;
    logic signed [63:0] prod2_reg, prod2_next;
    logic signed [31:0] cc;
    logic [30:0]        a_reg, a_next;
    logic [30:0]        b_reg;
    logic signed [CW-1:0] a_sum;

    // square roots and arctangent
    logic               sqrt_a_valid, sqrt_b_valid, atan_valid;
    logic [30:0]        sqrt_a, sqrt_b;
    logic signed [31:0] atan_z;

    // stages d, e: scale and subtract
    logic [20:0]        side_reg [0:SIDE_DEPTH-1];
    logic               vd_reg;
    logic [60:0]        prod3_reg, prod3_next;
    logic [19:0]        ref_d_reg;
    logic [29:0]        c30;
    logic [30:0]        scale;
    logic [60:0]        dist_full;
    logic               done_reg;
    logic signed [29:0] rem_reg, rem_next;

    assign busy = 1'b0;

    always_comb
    begin
        slat_p_next = 64'(start_latitude) * DEG_K_LO;
        slon_p_next = 64'(start_longitude) * DEG_K_LO;
        elat_p_next = 64'(end_latitude) * DEG_K_LO;
        elon_p_next = 64'(end_longitude) * DEG_K_LO;
    end

    always_comb
    begin
        dlat_next = elat_t_reg - slat_t_reg;
        dlon_next = elon_t_reg - slon_t_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            va_reg <= cdlat_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= atan_valid;
            done_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        slat_v_reg <= 32'(start_latitude);
        slon_v_reg <= start_longitude;
        elat_v_reg <= 32'(end_latitude);
        elon_v_reg <= end_longitude;
        slat_p_reg <= slat_p_next;
        slon_p_reg <= slon_p_next;
        elat_p_reg <= elat_p_next;
        elon_p_reg <= elon_p_next;

        slat_t_reg <= deg_turn(slat_v_reg, slat_p_reg);
        slon_t_reg <= deg_turn(slon_v_reg, slon_p_reg);
        elat_t_reg <= deg_turn(elat_v_reg, elat_p_reg);
        elon_t_reg <= deg_turn(elon_v_reg, elon_p_reg);

        dlat_reg <= dlat_next;
        dlon_reg <= dlon_next;
        lat1_reg <= slat_t_reg;
        lat2_reg <= elat_t_reg;
    end

    hdr_cordic u_cos_dlat (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (CORDIC_ROTATE),
        .in_valid  (v3_reg),
        .angle     (dlat_reg),
        .x_in      ('0),
        .y_in      ('0),
        .out_valid (cdlat_valid),
        .result    (cdlat)
    );

    hdr_cordic u_cos_dlon (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (CORDIC_ROTATE),
        .in_valid  (v3_reg),
        .angle     (dlon_reg),
        .x_in      ('0),
        .y_in      ('0),
        .out_valid (cdlon_valid),
        .result    (cdlon)
    );

    hdr_cordic u_cos_lat1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (CORDIC_ROTATE),
        .in_valid  (v3_reg),
        .angle     (lat1_reg),
        .x_in      ('0),
        .y_in      ('0),
        .out_valid (clat1_valid),
        .result    (clat1)
    );

    hdr_cordic u_cos_lat2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (CORDIC_ROTATE),
        .in_valid  (v3_reg),
        .angle     (lat2_reg),
        .x_in      ('0),
        .y_in      ('0),
        .out_valid (clat2_valid),
        .result    (clat2)
    );

    always_comb
    begin
        ccp_next   = 64'(clat1) * 64'(clat2);
        cc         = 32'(ccp_reg >>> 30);
        prod2_next = 64'(cc) * $signed({33'd0, hlon_a_reg});
        a_sum      = CW'(hlat_b_reg) + CW'(prod2_reg >>> 30);
        if (a_sum[CW-1])
        begin
            a_next = '0;
        end
        else if (a_sum > CW_Q30)
        begin
            a_next = 31'(CW_Q30);
        end
        else
        begin
            a_next = 31'(a_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        hlat_a_reg <= hav(cdlat);
        hlon_a_reg <= hav(cdlon);
        ccp_reg    <= ccp_next;
        hlat_b_reg <= hlat_a_reg;
        prod2_reg  <= prod2_next;
        a_reg      <= a_next;
        b_reg      <= 31'(CW_Q30) - a_next;
    end

    hdr_isqrt u_sqrt_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .value     (a_reg),
        .out_valid (sqrt_a_valid),
        .root      (sqrt_a)
    );

    hdr_isqrt u_sqrt_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vc_reg),
        .value     (b_reg),
        .out_valid (sqrt_b_valid),
        .root      (sqrt_b)
    );

    hdr_cordic u_atan (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (CORDIC_VECTOR),
        .in_valid  (sqrt_a_valid),
        .angle     ('0),
        .x_in      ($signed({1'b0, sqrt_b})),
        .y_in      ($signed({1'b0, sqrt_a})),
        .out_valid (atan_valid),
        .result    (atan_z)
    );

    // func and reference ride alongside the datapath
    always_ff @(posedge clk)
    begin
        side_reg[0] <= {func, reference_distance};
        for (int i = 1; i < SIDE_DEPTH; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    always_comb
    begin
        c30 = {atan_z[28:0], 1'b0};
        if (side_reg[SIDE_DEPTH-1][20] == FUNC_YARD)
        begin
            scale = SCALE_YARD;
        end
        else
        begin
            scale = SCALE_METER;
        end
        prod3_next = 61'(c30) * 61'(scale);
        dist_full  = (prod3_reg + DIST_ROUND) >> 33;
        rem_next   = $signed(30'(ref_d_reg)) - $signed(30'(dist_full));
    end

    always_ff @(posedge clk)
    begin
        prod3_reg <= prod3_next;
        ref_d_reg <= side_reg[SIDE_DEPTH-1][19:0];
        rem_reg   <= rem_next;
    end

    assign done               = done_reg;
    assign remaining_distance = rem_reg;

`ifndef SYNTHESIS
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cos_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (cdlat_valid == cdlon_valid) && (cdlat_valid == clat1_valid)
        && (cdlat_valid == clat2_valid))
        else $error("cosine lanes out of step");

    a_sqrt_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_a_valid == sqrt_b_valid)
        else $error("square root lanes out of step");

    a_hav_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg |-> (a_reg <= 31'(CW_Q30)))
        else $error("haversine term out of range");

    a_done_follows_atan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(atan_valid, 2))
        else $error("done without arctangent result");
`endif

endmodule
